>>> design/box_filter_mipmap_downsampler_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box filter mipmap downsampler
// Concurrent checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_MIPMAP_DOWNSAMPLER_UNIT_DEFINES_SVH
`define BOX_FILTER_MIPMAP_DOWNSAMPLER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BFMD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bfmd assertion failed");
`define BFMD_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("bfmd forbidden condition");
`else
`define BFMD_ASSERT(lbl, prop)
`define BFMD_NEVER(lbl, expr)
`endif

`endif

>>> design/bfmd_pkg.sv
// ----------------------------------------------------------------------------
// bfmd_pkg
// Shared constants, types and helpers of the box filter mipmap downsampler.
// ----------------------------------------------------------------------------
package bfmd_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_SHIFT  = 8;
    localparam int NUM_COLS   = MAX_WIDTH / 2;

    localparam int PIX_W   = 8;
    localparam int DIM_W   = 9;
    localparam int POS_W   = 8;
    localparam int SHIFT_W = 4;
    localparam int COL_W   = $clog2(NUM_COLS);
    localparam int SUM_W   = 24;
    localparam int CFG_W   = 9;
    localparam int CFG_AW  = 2;

    localparam int NUM_LANES = 3;
    localparam int IN_W      = NUM_LANES * PIX_W;
    localparam int OUT_W     = 40;

    // output queue depth, power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [CFG_AW-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_SHIFT  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [SHIFT_W-1:0] shift;
    } cfg_t;

    typedef struct packed {
        logic             valid;      // accepted pixel inside a whole block
        logic             first;      // top-left pixel of its block
        logic             last;       // bottom-right pixel, produces output
        logic [COL_W-1:0] col;        // block column
        logic [COL_W-1:0] row;        // block row
        logic             frame_last;
    } ctrl_t;

    typedef struct packed {
        logic             frame_last;
        logic [COL_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] avg_blue;
        logic [PIX_W-1:0] avg_green;
        logic [PIX_W-1:0] avg_red;
    } out_t;

    function automatic logic [POS_W-1:0] side_mask(input logic [SHIFT_W-1:0] sh);
        logic [POS_W:0] one_hot;
        one_hot = (POS_W+1)'(1) << sh;
        return POS_W'(one_hot - (POS_W+1)'(1));
    endfunction

endpackage

>>> design/bfmd_pos.sv
// ----------------------------------------------------------------------------
// bfmd_pos
// Raster position tracker; classifies each accepted pixel within its block.
// ----------------------------------------------------------------------------
module bfmd_pos (
    input  logic           clk,
    input  logic           rst_n,
    input  bfmd_pkg::cfg_t cfg,
    input  logic           restart,
    input  logic           accept,
    output bfmd_pkg::ctrl_t ctrl
);
    import bfmd_pkg::*;

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;

    logic [POS_W-1:0] mask;
    logic [POS_W-1:0] bx, by;
    logic [DIM_W-1:0] blocks_x, blocks_y;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic             in_range;

    always_comb
    begin
        mask     = side_mask(cfg.shift);
        bx       = col_reg >> cfg.shift;
        by       = row_reg >> cfg.shift;
        blocks_x = cfg.width >> cfg.shift;
        blocks_y = cfg.height >> cfg.shift;
        in_range = ({1'b0, bx} < blocks_x) && ({1'b0, by} < blocks_y);

        ctrl.valid      = accept && in_range;
        ctrl.first      = ((col_reg & mask) == '0) && ((row_reg & mask) == '0);
        ctrl.last       = ((col_reg & mask) == mask) && ((row_reg & mask) == mask);
        ctrl.col        = bx[COL_W-1:0];
        ctrl.row        = by[COL_W-1:0];
        ctrl.frame_last = ({1'b0, bx} == blocks_x - DIM_W'(1))
                       && ({1'b0, by} == blocks_y - DIM_W'(1));
    end

    always_comb
    begin
        col_inc  = {1'b0, col_reg} + DIM_W'(1);
        row_inc  = {1'b0, row_reg} + DIM_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_inc >= cfg.width)
            begin
                col_next = '0;
                row_next = (row_inc >= cfg.height) ? '0 : row_inc[POS_W-1:0];
            end
            else
            begin
                col_next = col_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> design/bfmd_lane.sv
// ----------------------------------------------------------------------------
// bfmd_lane
// One color channel: column sum memory, read-modify-write with bypass, and
// the final mean shift.
// ----------------------------------------------------------------------------
module bfmd_lane (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bfmd_pkg::ctrl_t           ctrl,
    input  logic [bfmd_pkg::PIX_W-1:0]   pix,
    input  logic [bfmd_pkg::SHIFT_W-1:0] shift,
    output logic [bfmd_pkg::PIX_W-1:0]   avg
);
    import bfmd_pkg::*;

    logic [SUM_W-1:0] mem [NUM_COLS];
    logic [SUM_W-1:0] rdata_reg;

    logic             v1_reg;
    logic             first1_reg;
    logic             last1_reg;
    logic [COL_W-1:0] addr1_reg;
    logic [PIX_W-1:0] pix1_reg;

    // record of the write issued last cycle, not yet visible in rdata_reg
    logic             wr_v_reg;
    logic [COL_W-1:0] wr_addr_reg;
    logic [SUM_W-1:0] wr_data_reg;

    logic [SUM_W-1:0] base;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] shifted;
    logic [PIX_W-1:0] avg_reg, avg_next;

    always_comb
    begin
        base     = (wr_v_reg && (wr_addr_reg == addr1_reg)) ? wr_data_reg : rdata_reg;
        sum      = first1_reg ? SUM_W'(pix1_reg) : base + SUM_W'(pix1_reg);
        shifted  = sum >> {shift, 1'b0};
        avg_next = shifted[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            rdata_reg <= mem[ctrl.col];
        end
        if (v1_reg)
        begin
            mem[addr1_reg] <= sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            wr_v_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= ctrl.valid;
            wr_v_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        first1_reg  <= ctrl.first;
        last1_reg   <= ctrl.last;
        addr1_reg   <= ctrl.col;
        pix1_reg    <= pix;
        wr_addr_reg <= addr1_reg;
        wr_data_reg <= sum;
        if (v1_reg && last1_reg)
        begin
            avg_reg <= avg_next;
        end
    end

    assign avg = avg_reg;

endmodule

>>> design/bfmd_merge.sv
// ----------------------------------------------------------------------------
// bfmd_merge
// Joins the three lane means with the block position and queues the result
// pixels for the output stream; derives input ready from queue credit.
// ----------------------------------------------------------------------------
`include "box_filter_mipmap_downsampler_unit_defines.svh"

module bfmd_merge (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bfmd_pkg::ctrl_t         ctrl,
    input  logic [bfmd_pkg::PIX_W-1:0] avg_red,
    input  logic [bfmd_pkg::PIX_W-1:0] avg_green,
    input  logic [bfmd_pkg::PIX_W-1:0] avg_blue,
    input  logic                    out_ready,
    output logic                    out_valid,
    output bfmd_pkg::out_t          out_item,
    output logic                    in_ready
);
    import bfmd_pkg::*;

    logic             e1_reg, e2_reg;
    logic [COL_W-1:0] col1_reg, col2_reg;
    logic [COL_W-1:0] row1_reg, row2_reg;
    logic             fl1_reg, fl2_reg;

    out_t               fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic [FIFO_AW+1:0] occupancy;

    logic push, pop;
    out_t entry;

    assign push = e2_reg;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        entry.frame_last = fl2_reg;
        entry.row        = row2_reg;
        entry.col        = col2_reg;
        entry.avg_blue   = avg_blue;
        entry.avg_green  = avg_green;
        entry.avg_red    = avg_red;
    end

    // results still in the lanes hold a slot in advance
    assign occupancy = (FIFO_AW+2)'(count_reg) + (FIFO_AW+2)'(e1_reg)
                     + (FIFO_AW+2)'(e2_reg);
    assign in_ready  = occupancy < (FIFO_AW+2)'(FIFO_DEPTH);

    assign out_valid = count_reg != '0;
    assign out_item  = fifo[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (FIFO_AW+1)'(1);
            2'b01:   count_next = count_reg - (FIFO_AW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg     <= 1'b0;
            e2_reg     <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            e1_reg    <= ctrl.valid && ctrl.last;
            e2_reg    <= e1_reg;
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col1_reg <= ctrl.col;
        row1_reg <= ctrl.row;
        fl1_reg  <= ctrl.frame_last;
        col2_reg <= col1_reg;
        row2_reg <= row1_reg;
        fl2_reg  <= fl1_reg;
        if (push)
        begin
            fifo[wr_ptr_reg] <= entry;
        end
    end

    `BFMD_ASSERT(a_credit_bound, occupancy <= (FIFO_AW+2)'(FIFO_DEPTH))
    `BFMD_NEVER(a_no_overflow, push && !pop && (count_reg == (FIFO_AW+1)'(FIFO_DEPTH)))
    `BFMD_ASSERT(a_emit_has_credit, (ctrl.valid && ctrl.last) |-> in_ready)
    `BFMD_ASSERT(a_empty_stays, (count_reg == '0 && !e2_reg) |=> !out_valid)

endmodule

>>> design/box_filter_mipmap_downsampler_unit.sv
// ----------------------------------------------------------------------------
// box_filter_mipmap_downsampler_unit: RGB888 box filter, one mip level a pass
// Output: a block's result passes the lane pipeline registers, the mean register and the output queue to m_tvalid.
// Throughput: 1 pixel/cycle, RMW bypassed; s_tready low while 4 queue slots are held.
// Reset: async rst_n; regs 256/256/1, position 0,0, output queue empty.
// ----------------------------------------------------------------------------
module box_filter_mipmap_downsampler_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [bfmd_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [bfmd_pkg::CFG_W-1:0]     cfg_data,
    // pixel input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bfmd_pkg::IN_W-1:0]      s_tdata,   // red, green, blue
    // reduced image output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // avg_red, avg_green, avg_blue, out_col, out_row, zero pad
    output logic [bfmd_pkg::OUT_W-1:0]     m_tdata,
    output logic                           m_tlast    // frame_last
);
    import bfmd_pkg::*;

    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic               restart;

    cfg_t  cfg;
    ctrl_t ctrl;
    out_t  item;
    logic  accept;

    logic [PIX_W-1:0] lane_pix [NUM_LANES];
    logic [PIX_W-1:0] lane_avg [NUM_LANES];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        shift_next  = shift_reg;
        restart     = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_WIDTH:
                begin
                    width_next = cfg_data;
                    restart    = 1'b1;
                end
                CFG_HEIGHT:
                begin
                    height_next = cfg_data;
                    restart     = 1'b1;
                end
                CFG_SHIFT:
                begin
                    shift_next = cfg_data[SHIFT_W-1:0];
                    restart    = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
            shift_reg  <= SHIFT_W'(1);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            shift_reg  <= shift_next;
        end
    end

    // out-of-range settings clamp to the nearest legal value
    always_comb
    begin
        if (width_reg == '0)
            cfg.width = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            cfg.width = DIM_W'(MAX_WIDTH);
        else
            cfg.width = width_reg;

        if (height_reg == '0)
            cfg.height = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            cfg.height = DIM_W'(MAX_HEIGHT);
        else
            cfg.height = height_reg;

        if (shift_reg == '0)
            cfg.shift = SHIFT_W'(1);
        else if (shift_reg > SHIFT_W'(MAX_SHIFT))
            cfg.shift = SHIFT_W'(MAX_SHIFT);
        else
            cfg.shift = shift_reg;
    end

    assign accept = s_tvalid && s_tready;

    bfmd_pos u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .restart (restart),
        .accept  (accept),
        .ctrl    (ctrl)
    );

    genvar i;
    generate
        for (i = 0; i < NUM_LANES; i++)
        begin : g_lane
            assign lane_pix[i] = s_tdata[i*PIX_W +: PIX_W];

            bfmd_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .pix   (lane_pix[i]),
                .shift (cfg.shift),
                .avg   (lane_avg[i])
            );
        end
    endgenerate

    bfmd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .avg_red   (lane_avg[0]),
        .avg_green (lane_avg[1]),
        .avg_blue  (lane_avg[2]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_item  (item),
        .in_ready  (s_tready)
    );

    assign m_tdata = {(OUT_W - 3*PIX_W - 2*COL_W)'(0), item.row, item.col,
                      item.avg_blue, item.avg_green, item.avg_red};
    assign m_tlast = item.frame_last;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: box filter mipmap downsampler testbench
// Streams RGB pixels through several image sizes and block shifts, predicts
// every block mean in a scoreboard and compares each output transaction
// field by field, under random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import bfmd_pkg::*;

    localparam logic [CFG_AW-1:0] CFG_NONE = CFG_AW'(3);  // decoded by nothing
    localparam int IDLE_LIMIT     = 2000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PIXELS  = 300;
    localparam int MIN_PHASES     = 5;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [6:0] col;
        logic [6:0] row;
        logic       last;
    } block_mean_t;

    class mip_level_scoreboard;
        logic [8:0]  width_reg;
        logic [8:0]  height_reg;
        logic [3:0]  shift_reg;
        logic [23:0] red_sums[NUM_COLS];
        logic [23:0] green_sums[NUM_COLS];
        logic [23:0] blue_sums[NUM_COLS];
        int          col_pos;
        int          row_pos;
        int          errors;
        int          block_pixels;
        block_mean_t expected_means[$];

        function new();
            width_reg  = 9'd256;
            height_reg = 9'd256;
            shift_reg  = 4'd1;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
            block_pixels = 0;
            foreach (red_sums[i])
            begin
                red_sums[i]   = '0;
                green_sums[i] = '0;
                blue_sums[i]  = '0;
            end
        endfunction

        function void write_reg(logic [CFG_AW-1:0] idx, logic [8:0] value);
            case (idx)
                CFG_WIDTH:  width_reg  = value;
                CFG_HEIGHT: height_reg = value;
                CFG_SHIFT:  shift_reg  = value[3:0];
                default:    return;
            endcase
            // any decoded write restarts the frame
            col_pos = 0;
            row_pos = 0;
        endfunction

        function void note_pixel(logic [23:0] px);
            int          w;
            int          h;
            int          sh;
            int          mask;
            int          across;
            int          down;
            int          c;
            int          r;
            int          bx;
            int          by;
            block_mean_t m;
            w  = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
            h  = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
            sh = (shift_reg == 0) ? 1 : ((shift_reg > MAX_SHIFT) ? MAX_SHIFT : shift_reg);
            mask   = (1 << sh) - 1;
            across = w >> sh;
            down   = h >> sh;
            if (col_pos >= w)
                col_pos = 0;
            if (row_pos >= h)
                row_pos = 0;
            c  = col_pos;
            r  = row_pos;
            bx = c >> sh;
            by = r >> sh;
            if (bx < across && by < down)
            begin
                block_pixels++;
                if ((r & mask) == 0 && (c & mask) == 0)
                begin
                    red_sums[bx]   = 24'(px[7:0]);
                    green_sums[bx] = 24'(px[15:8]);
                    blue_sums[bx]  = 24'(px[23:16]);
                end
                else
                begin
                    red_sums[bx]   += 24'(px[7:0]);
                    green_sums[bx] += 24'(px[15:8]);
                    blue_sums[bx]  += 24'(px[23:16]);
                end
                if ((r & mask) == mask && (c & mask) == mask)
                begin
                    m.red   = 8'(red_sums[bx] >> (2 * sh));
                    m.green = 8'(green_sums[bx] >> (2 * sh));
                    m.blue  = 8'(blue_sums[bx] >> (2 * sh));
                    m.col   = 7'(bx);
                    m.row   = 7'(by);
                    m.last  = (bx == across - 1 && by == down - 1);
                    expected_means.push_back(m);
                end
            end
            if (c + 1 >= w)
            begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : r + 1;
            end
            else
                col_pos = c + 1;
        endfunction

        function void compare_field(string label, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch %s: expected %0d, actual %0d", label, want, got);
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] d, logic last);
            block_mean_t m;
            if (expected_means.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output transaction: data %h last %b", d, last);
                return;
            end
            m = expected_means.pop_front();
            compare_field("avg_red", m.red, d[7:0]);
            compare_field("avg_green", m.green, d[15:8]);
            compare_field("avg_blue", m.blue, d[23:16]);
            compare_field("out_col", 8'(m.col), 8'(d[30:24]));
            compare_field("out_row", 8'(m.row), 8'(d[37:31]));
            compare_field("frame_last", 8'(m.last), 8'(last));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_W-1:0]  cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;   // red, green, blue
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;   // avg_red, avg_green, avg_blue, out_col, out_row, pad
    logic              m_tlast;   // frame_last

    bit rx_hold    = 1'b0;
    bit calm_links = 1'b0;
    int idle_cycles = 0;

    mip_level_scoreboard sb = new();

    box_filter_mipmap_downsampler_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // monitors: both streams sampled at the edge where the transaction lands
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_pixel(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin : result_side
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            m_tready <= calm_links || ($urandom_range(99) >= 7);
        end
    end

    function automatic logic [7:0] pick_channel();
        if ($urandom_range(4) == 0)
            return $urandom_range(1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        if (!calm_links && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // drops valid and waits until every predicted mean has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_means.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixels(input int count, input int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                settle();
            send_pixel(pick_channel(), pick_channel(), pick_channel());
        end
    endtask

    task automatic set_reg(input logic [CFG_AW-1:0] idx, input logic [8:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int w;
        int h;
        int sh;
        int n;
        int phase;
        int start_pixels;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        cfg_we   = 1'b0;
        cfg_addr = CFG_WIDTH;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings; the first row alone gives no result
        send_pixels(8, -1);
        settle();

        // shift 0 behaves as 1; channel extremes
        set_reg(CFG_WIDTH, 9'd2);
        set_reg(CFG_HEIGHT, 9'd2);
        set_reg(CFG_SHIFT, 9'd0);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        settle();
        // undecoded index must leave the position alone
        send_pixels(2, -1);
        settle();
        set_reg(CFG_NONE, 9'h1FF);
        send_pixels(2, -1);
        settle();
        // decoded write restarts the frame mid block
        send_pixels(2, -1);
        settle();
        set_reg(CFG_HEIGHT, 9'd2);
        send_pixels(4, -1);
        settle();
        // zero sizes act as 1, block bigger than the image
        set_reg(CFG_WIDTH, 9'd0);
        set_reg(CFG_HEIGHT, 9'd0);
        set_reg(CFG_SHIFT, 9'd8);
        send_pixels(3, -1);
        settle();
        // partial column dropped, frame wraps
        set_reg(CFG_WIDTH, 9'd3);
        set_reg(CFG_HEIGHT, 9'd2);
        set_reg(CFG_SHIFT, 9'd1);
        send_pixels(12, -1);
        settle();

        start_pixels = sb.block_pixels;
        phase = 0;
        while (phase < MIN_PHASES || sb.block_pixels - start_pixels < RANDOM_PIXELS)
        begin
            calm_links = (phase == 2);
            if (phase == 4)
            begin
                // output side stalls while small blocks keep producing means
                set_reg(CFG_WIDTH, 9'd4);
                set_reg(CFG_HEIGHT, 9'd16);
                set_reg(CFG_SHIFT, 9'd1);
                rx_hold = 1'b1;
                send_pixels(96, -1);
            end
            else if ($urandom_range(9) < 6)
            begin
                // whole frames
                w  = $urandom_range(2, 12);
                h  = $urandom_range(2, 8);
                sh = ($urandom_range(3) == 0) ? 2 : 1;
                n  = w * h * $urandom_range(1, 2);
                set_reg(CFG_WIDTH, 9'(w));
                set_reg(CFG_HEIGHT, 9'(h));
                set_reg(CFG_SHIFT, {5'($urandom), 4'(sh)});
                send_pixels(n, (phase == 6) ? n / 2 : -1);
            end
            else
            begin
                // odd sizes, partial frames, some registers left as they were
                case ($urandom_range(2))
                    0:       w = 0;
                    1:       w = $urandom_range(1, 20);
                    default: w = $urandom_range(257, 511);
                endcase
                case ($urandom_range(2))
                    0:       h = 0;
                    1:       h = $urandom_range(1, 10);
                    default: h = $urandom_range(257, 511);
                endcase
                case ($urandom_range(2))
                    0:       sh = 0;
                    1:       sh = $urandom_range(1, 3);
                    default: sh = $urandom_range(9, 15);
                endcase
                if ($urandom_range(1))
                    set_reg(CFG_WIDTH, 9'(w));
                if ($urandom_range(1))
                    set_reg(CFG_HEIGHT, 9'(h));
                if ($urandom_range(1))
                    set_reg(CFG_SHIFT, {5'($urandom), 4'(sh)});
                if ($urandom_range(3) == 0)
                    set_reg(CFG_NONE, 9'($urandom));
                send_pixels($urandom_range(5, 40), -1);
            end
            settle();
            phase++;
        end
        calm_links = 1'b0;

        // every register beyond range: 256x256 at the largest shift, no whole
        // block within a short run
        set_reg(CFG_WIDTH, 9'h1FF);
        set_reg(CFG_HEIGHT, 9'd300);
        set_reg(CFG_SHIFT, 9'd15);
        send_pixels(16, -1);
        settle();
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.expected_means.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/bfmd_pkg.sv
design/bfmd_pos.sv
design/bfmd_lane.sv
design/bfmd_merge.sv
design/box_filter_mipmap_downsampler_unit.sv
dv/tb_top.sv
